// File: hw/rtl/tbte_pkg.sv
package tbte_pkg;

  localparam int MAX_BLOCK   = 32768;
  localparam int QUEUE_DEPTH = 4;

  // block position saturates at the smaller of MAX_BLOCK - 1 and 32767
  localparam logic [14:0] BLOCK_CAP =
    15'((MAX_BLOCK - 1 < 32767) ? MAX_BLOCK - 1 : 32767);
  localparam logic [14:0] RECORD_CAP = 15'h7FFF;

  localparam logic [7:0] MARK_BYTE = 8'o217;

  localparam logic [11:0] RECORD_LENGTH_RST = 12'd80;
  localparam logic [14:0] BLOCK_LENGTH_RST  = 15'd84;

  localparam logic [1:0] CFG_ALT_CHARSET   = 2'd0;
  localparam logic [1:0] CFG_RECORD_LENGTH = 2'd1;
  localparam logic [1:0] CFG_BLOCK_LENGTH  = 2'd2;

  typedef enum logic [2:0] {
    OP_CHAR,
    OP_TAB,
    OP_NL,
    OP_MARK,
    OP_EOT
  } op_t;

  // code: parity plus six-bit BCD, block start flag is added in the back end
  typedef struct packed {
    op_t        op;
    logic [6:0] code;
  } q_entry_t;

  typedef struct packed {
    logic        alt_charset;
    logic [11:0] record_length;
    logic [14:0] block_length;
  } cfg_t;

endpackage

// File: hw/rtl/tbte_front.sv
module tbte_front (
  input  logic                clk,
  input  logic                rst_n,
  input  tbte_pkg::cfg_t      cfg,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_action,
  input  logic [6:0]          in_text_char,
  output logic                q_push,
  output tbte_pkg::q_entry_t  q_wdata,
  input  logic                q_full
);

  localparam logic [6:0] CH_TAB   = 7'h09;
  localparam logic [6:0] CH_NL    = 7'h0A;
  localparam logic [6:0] CH_FF    = 7'h0C;
  localparam logic [6:0] CH_CR    = 7'h0D;
  localparam logic [6:0] CH_SPACE = 7'h20;
  localparam logic [6:0] CH_TILDE = 7'h7E;

  function automatic logic [5:0] bcd_code(input logic alt, input logic [6:0] ch);
    logic [6:0] u;
    logic [5:0] c;
    u = ch;
    if (ch >= 7'h61 && ch <= 7'h7A) u = ch - 7'h20;
    c = alt ? 6'o20 : 6'o60;
    if (u >= 7'h41 && u <= 7'h49) begin
      c = (alt ? 6'o61 : 6'o21) + 6'(u - 7'h41);
    end else if (u >= 7'h4A && u <= 7'h52) begin
      c = 6'o41 + 6'(u - 7'h4A);
    end else if (u >= 7'h53 && u <= 7'h5A) begin
      c = (alt ? 6'o22 : 6'o62) + 6'(u - 7'h53);
    end else if (u >= 7'h31 && u <= 7'h39) begin
      c = 6'(u - 7'h30);
    end else if (!alt) begin
      case (ch)
        7'h21: c = 6'o52;
        7'h24: c = 6'o53;
        7'h27: c = 6'o14;
        7'h28: c = 6'o74;
        7'h29: c = 6'o34;
        7'h2A: c = 6'o54;
        7'h2B: c = 6'o20;
        7'h2C: c = 6'o73;
        7'h2D: c = 6'o40;
        7'h2E: c = 6'o33;
        7'h2F: c = 6'o61;
        7'h30: c = 6'o00;
        7'h3D: c = 6'o13;
        7'h3F: c = 6'o32;
        default: c = 6'o60;
      endcase
    end else begin
      case (ch)
        7'h21: c = 6'o52;
        7'h22: c = 6'o37;
        7'h24: c = 6'o53;
        7'h27: c = 6'o14;
        7'h28: c = 6'o34;
        7'h29: c = 6'o74;
        7'h2A: c = 6'o54;
        7'h2B: c = 6'o60;
        7'h2C: c = 6'o33;
        7'h2D: c = 6'o40;
        7'h2E: c = 6'o73;
        7'h2F: c = 6'o21;
        7'h30: c = 6'o12;
        7'h3B: c = 6'o56;
        7'h3C: c = 6'o76;
        7'h3D: c = 6'o13;
        7'h3E: c = 6'o16;
        7'h3F: c = 6'o72;
        7'h5B: c = 6'o75;
        7'h5C: c = 6'o36;
        7'h5D: c = 6'o55;
        7'h5F: c = 6'o57;
        7'h7B: c = 6'o17;
        7'h7C: c = 6'o32;
        7'h7D: c = 6'o77;
        7'h7E: c = 6'o35;
        default: c = 6'o20;
      endcase
    end
    return c;
  endfunction

  // even parity lands in bit 6
  function automatic logic [6:0] tape_code(input logic alt, input logic [6:0] ch);
    logic [5:0] c;
    c = bcd_code(alt, ch);
    return {^c, c};
  endfunction

  logic       skip_r, skip_nxt;
  logic       keep;
  logic       accept;
  logic [6:0] char_code;
  logic [6:0] blank_code;

  assign in_stall   = q_full;
  assign accept     = in_valid && !q_full;
  assign char_code  = tape_code(cfg.alt_charset, in_text_char);
  assign blank_code = tape_code(cfg.alt_charset, CH_SPACE);

  always_comb begin
    keep         = 1'b1;
    skip_nxt     = skip_r;
    q_wdata.op   = tbte_pkg::OP_CHAR;
    q_wdata.code = char_code;
    if (in_action) begin
      q_wdata.op   = tbte_pkg::OP_EOT;
      q_wdata.code = blank_code;
      skip_nxt     = 1'b0;
    end else if (skip_r) begin
      keep = 1'b0;
      if (in_text_char == CH_NL) skip_nxt = 1'b0;
    end else if (in_text_char == CH_CR) begin
      keep = 1'b0;
    end else if (in_text_char == CH_NL) begin
      q_wdata.op   = tbte_pkg::OP_NL;
      q_wdata.code = blank_code;
    end else if (in_text_char == CH_FF || in_text_char == CH_TILDE) begin
      q_wdata.op = tbte_pkg::OP_MARK;
      skip_nxt   = 1'b1;
    end else if (in_text_char == CH_TAB) begin
      q_wdata.op   = tbte_pkg::OP_TAB;
      q_wdata.code = blank_code;
    end
  end

  assign q_push = accept && keep;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_r <= 1'b0;
    end else if (accept) begin
      skip_r <= skip_nxt;
    end
  end

endmodule

// File: hw/rtl/tbte_queue.sv
module tbte_queue #(
  parameter int DEPTH = tbte_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  tbte_pkg::q_entry_t  wdata,
  output logic                full,
  input  logic                pop,
  output tbte_pkg::q_entry_t  rdata,
  output logic                not_empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  tbte_pkg::q_entry_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push, do_pop;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign rdata     = mem_r[rd_ptr_r];

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wrap_inc(wr_ptr_r);
      if (do_pop)  rd_ptr_r <= wrap_inc(rd_ptr_r);
      if (do_push && !do_pop)      count_r <= count_r + CW'(1);
      else if (do_pop && !do_push) count_r <= count_r - CW'(1);
    end
  end

endmodule

// File: hw/rtl/tbte_back.sv
module tbte_back (
  input  logic                clk,
  input  logic                rst_n,
  input  tbte_pkg::cfg_t      cfg,
  input  logic                q_valid,
  input  tbte_pkg::q_entry_t  q_rdata,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_tape_byte,
  output logic [14:0]         out_run_length,
  output logic                out_last_of_run
);

  typedef enum logic [6:0] {
    S_FETCH    = 7'b0000001,
    S_TAB_FILL = 7'b0000010,
    S_NL_SUM   = 7'b0000100,
    S_NL_TEST  = 7'b0001000,
    S_PAD_REC  = 7'b0010000,
    S_PAD_BLK  = 7'b0100000,
    S_MARK2    = 7'b1000000
  } back_state_t;

  function automatic logic [14:0] blk_add(input logic [14:0] a, input logic [14:0] n);
    logic [15:0] s;
    s = {1'b0, a} + {1'b0, n};
    return (s > {1'b0, tbte_pkg::BLOCK_CAP}) ? tbte_pkg::BLOCK_CAP : s[14:0];
  endfunction

  function automatic logic [14:0] rec_add(input logic [14:0] a, input logic [14:0] n);
    logic [15:0] s;
    s = {1'b0, a} + {1'b0, n};
    return (s > {1'b0, tbte_pkg::RECORD_CAP}) ? tbte_pkg::RECORD_CAP : s[14:0];
  endfunction

  back_state_t state_r, state_nxt;
  logic [14:0] blk_r, blk_nxt;
  logic [14:0] rec_r, rec_nxt;
  logic [14:0] cnt_r, cnt_nxt;
  logic [14:0] bcnt_r, bcnt_nxt;
  logic [14:0] blkp_r, blkp_nxt;
  logic        close_r, close_nxt;
  logic        more_r, more_nxt;
  logic        eot_r, eot_nxt;
  logic [2:0]  fill_r, fill_nxt;
  logic [6:0]  code_r, code_nxt;

  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  logic [14:0] out_len_r;
  logic        out_last_r;

  logic        adv;
  logic        emit;
  logic [7:0]  e_byte;
  logic [14:0] e_len;
  logic        e_last;
  logic [2:0]  tab_fill;
  logic [14:0] rl_ext;
  logic [15:0] test_sum;
  logic        pad_flag;
  logic [14:0] pad_cnt;
  logic [14:0] pad_blk;

  assign adv    = !out_valid_r || !out_stall;
  assign rl_ext = {3'b000, cfg.record_length};
  // blanks needed to reach the next multiple of eight after this one
  assign tab_fill = ~rec_r[2:0];
  assign test_sum = {1'b0, blkp_r} + {4'b0000, cfg.record_length};

  // one step of a blank run: a flagged single blank at block start, else the rest
  assign pad_flag = (blk_r == '0);
  assign pad_cnt  = pad_flag ? cnt_r - 15'd1 : '0;
  assign pad_blk  = blk_add(blk_r, pad_flag ? 15'd1 : cnt_r);

  always_comb begin
    state_nxt = state_r;
    blk_nxt   = blk_r;
    rec_nxt   = rec_r;
    cnt_nxt   = cnt_r;
    bcnt_nxt  = bcnt_r;
    blkp_nxt  = blkp_r;
    close_nxt = close_r;
    more_nxt  = more_r;
    eot_nxt   = eot_r;
    fill_nxt  = fill_r;
    code_nxt  = code_r;
    q_pop     = 1'b0;
    emit      = 1'b0;
    e_byte    = '0;
    e_len     = 15'd1;
    e_last    = 1'b1;
    unique case (state_r)
      S_FETCH: begin
        if (adv && q_valid) begin
          q_pop    = 1'b1;
          code_nxt = q_rdata.code;
          unique case (q_rdata.op)
            tbte_pkg::OP_CHAR: begin
              emit    = 1'b1;
              e_byte  = {blk_r == '0, q_rdata.code};
              blk_nxt = blk_add(blk_r, 15'd1);
              rec_nxt = rec_add(rec_r, 15'd1);
            end
            tbte_pkg::OP_MARK: begin
              emit    = 1'b1;
              e_byte  = tbte_pkg::MARK_BYTE;
              blk_nxt = '0;
            end
            tbte_pkg::OP_TAB: begin
              emit     = 1'b1;
              e_byte   = {blk_r == '0, q_rdata.code};
              e_last   = (tab_fill == '0);
              blk_nxt  = blk_add(blk_r, 15'd1);
              rec_nxt  = rec_add(rec_r, 15'd1);
              fill_nxt = tab_fill;
              if (tab_fill != '0) state_nxt = S_TAB_FILL;
            end
            tbte_pkg::OP_NL: begin
              cnt_nxt   = (rl_ext > rec_r) ? rl_ext - rec_r : '0;
              rec_nxt   = '0;
              eot_nxt   = 1'b0;
              state_nxt = S_NL_SUM;
            end
            tbte_pkg::OP_EOT: begin
              cnt_nxt   = (rec_r != '0 && rl_ext > rec_r) ? rl_ext - rec_r : '0;
              rec_nxt   = '0;
              eot_nxt   = 1'b1;
              more_nxt  = 1'b1;
              state_nxt = S_PAD_REC;
            end
            default: ;
          endcase
        end
      end
      S_TAB_FILL: begin
        if (adv) begin
          emit      = 1'b1;
          e_byte    = {1'b0, code_r};
          e_len     = {12'd0, fill_r};
          blk_nxt   = blk_add(blk_r, {12'd0, fill_r});
          rec_nxt   = rec_add(rec_r, {12'd0, fill_r});
          state_nxt = S_FETCH;
        end
      end
      S_NL_SUM: begin
        blkp_nxt  = blk_add(blk_r, cnt_r);
        state_nxt = S_NL_TEST;
      end
      S_NL_TEST: begin
        close_nxt = (test_sum > {1'b0, cfg.block_length});
        bcnt_nxt  = (close_nxt && blkp_r < cfg.block_length) ?
                    cfg.block_length - blkp_r : '0;
        more_nxt  = (bcnt_nxt != '0);
        state_nxt = S_PAD_REC;
      end
      S_PAD_REC: begin
        if (adv) begin
          if (cnt_r != '0) begin
            emit    = 1'b1;
            e_byte  = {pad_flag, code_r};
            e_len   = pad_flag ? 15'd1 : cnt_r;
            e_last  = (pad_cnt == '0) && !more_r;
            blk_nxt = pad_blk;
            cnt_nxt = pad_cnt;
          end
          if (cnt_r == '0 || pad_cnt == '0) begin
            if (eot_r) begin
              state_nxt = S_MARK2;
            end else begin
              cnt_nxt   = bcnt_r;
              state_nxt = S_PAD_BLK;
            end
          end
        end
      end
      S_PAD_BLK: begin
        if (adv) begin
          if (cnt_r != '0) begin
            emit    = 1'b1;
            e_byte  = {pad_flag, code_r};
            e_len   = pad_flag ? 15'd1 : cnt_r;
            e_last  = (pad_cnt == '0);
            blk_nxt = pad_blk;
            cnt_nxt = pad_cnt;
          end
          if (cnt_r == '0 || pad_cnt == '0) begin
            if (close_r) blk_nxt = '0;
            state_nxt = S_FETCH;
          end
        end
      end
      S_MARK2: begin
        if (adv) begin
          emit      = 1'b1;
          e_byte    = tbte_pkg::MARK_BYTE;
          e_len     = 15'd2;
          blk_nxt   = '0;
          state_nxt = S_FETCH;
        end
      end
      default: state_nxt = S_FETCH;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_FETCH;
      blk_r       <= '0;
      rec_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      blk_r   <= blk_nxt;
      rec_r   <= rec_nxt;
      if (adv) out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r   <= cnt_nxt;
    bcnt_r  <= bcnt_nxt;
    blkp_r  <= blkp_nxt;
    close_r <= close_nxt;
    more_r  <= more_nxt;
    eot_r   <= eot_nxt;
    fill_r  <= fill_nxt;
    code_r  <= code_nxt;
    if (adv && emit) begin
      out_byte_r <= e_byte;
      out_len_r  <= e_len;
      out_last_r <= e_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_tape_byte   = out_byte_r;
  assign out_run_length  = out_len_r;
  assign out_last_of_run = out_last_r;

endmodule

// File: hw/rtl/text_to_bcd_tape_encoder_unit.sv
// Channel   Handshake              Payload
// in        in_valid / in_stall    in_action, in_text_char
// out       out_valid / out_stall  out_tape_byte, out_run_length, out_last_of_run
// cfg       cfg_wr_en              cfg_index, cfg_wdata
//
// An item is classified and queued in its accept cycle; CR and skipped text are dropped.
// Back end takes a queued item only when done with the last: a character or mark gives one
// run, a tab a blank plus any fill run, a newline a sum and block test, then record and
// block pad runs, end of text record pad runs and a double mark.
// Synchronous active-low reset clears positions, skip flag, queue and output valid flag.
// The input stalls only while the queue is full; out_stall holds the output register.
module text_to_bcd_tape_encoder_unit #(
  parameter int QUEUE_DEPTH = tbte_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [14:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [6:0]  in_text_char,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_tape_byte,
  output logic [14:0] out_run_length,
  output logic        out_last_of_run
);

  tbte_pkg::cfg_t     cfg_r;
  tbte_pkg::q_entry_t q_wdata, q_rdata;
  logic               q_push, q_full, q_pop, q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.alt_charset   <= 1'b0;
      cfg_r.record_length <= tbte_pkg::RECORD_LENGTH_RST;
      cfg_r.block_length  <= tbte_pkg::BLOCK_LENGTH_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        tbte_pkg::CFG_ALT_CHARSET:   cfg_r.alt_charset   <= cfg_wdata[0];
        tbte_pkg::CFG_RECORD_LENGTH: cfg_r.record_length <= cfg_wdata[11:0];
        tbte_pkg::CFG_BLOCK_LENGTH:  cfg_r.block_length  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  tbte_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_action    (in_action),
    .in_text_char (in_text_char),
    .q_push       (q_push),
    .q_wdata      (q_wdata),
    .q_full       (q_full)
  );

  tbte_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wdata     (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .rdata     (q_rdata),
    .not_empty (q_valid)
  );

  tbte_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .q_valid         (q_valid),
    .q_rdata         (q_rdata),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_tape_byte   (out_tape_byte),
    .out_run_length  (out_run_length),
    .out_last_of_run (out_last_of_run)
  );

endmodule

// File: verif/tape_text_pkg.sv
`timescale 1ns / 1ps

package tape_text_pkg;

  localparam logic ACT_TEXT = 1'b0;
  localparam logic ACT_END  = 1'b1;

  localparam logic [6:0] CH_TAB   = 7'h09;
  localparam logic [6:0] CH_LF    = 7'h0A;
  localparam logic [6:0] CH_FF    = 7'h0C;
  localparam logic [6:0] CH_CR    = 7'h0D;
  localparam logic [6:0] CH_SPACE = 7'h20;
  localparam logic [6:0] CH_TILDE = 7'h7E;

endpackage

// File: verif/tape_checker.sv
`timescale 1ns / 1ps

module tape_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [14:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_action,
  input  logic [6:0]  in_text_char,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_tape_byte,
  input  logic [14:0] out_run_length,
  input  logic        out_last_of_run,
  output int          fail_count,
  output int          runs_due
);
  import tbte_pkg::*;
  import tape_text_pkg::*;

  typedef struct packed {
    logic [7:0]  tape_byte;
    logic [14:0] run_length;
    logic        last_of_run;
  } tape_run_t;

  localparam logic [7:0] START_BIT = 8'o200;

  logic [5:0] std_bcd [0:127] = '{
    'o60,'o60,'o60,'o60,'o60,'o60,'o60,'o60,'o60,'o60,'o60,'o60,'o60,'o60,'o60,'o60,
    'o60,'o60,'o60,'o60,'o60,'o60,'o60,'o60,'o60,'o60,'o60,'o60,'o60,'o60,'o60,'o60,
    'o60,'o52,'o60,'o60,'o53,'o60,'o60,'o14,'o74,'o34,'o54,'o20,'o73,'o40,'o33,'o61,
    'o00,'o01,'o02,'o03,'o04,'o05,'o06,'o07,'o10,'o11,'o60,'o60,'o60,'o13,'o60,'o32,
    'o60,'o21,'o22,'o23,'o24,'o25,'o26,'o27,'o30,'o31,'o41,'o42,'o43,'o44,'o45,'o46,
    'o47,'o50,'o51,'o62,'o63,'o64,'o65,'o66,'o67,'o70,'o71,'o60,'o60,'o60,'o60,'o60,
    'o60,'o21,'o22,'o23,'o24,'o25,'o26,'o27,'o30,'o31,'o41,'o42,'o43,'o44,'o45,'o46,
    'o47,'o50,'o51,'o62,'o63,'o64,'o65,'o66,'o67,'o70,'o71,'o60,'o60,'o60,'o60,'o60
  };

  logic [5:0] alt_bcd [0:127] = '{
    'o20,'o20,'o20,'o20,'o20,'o20,'o20,'o20,'o20,'o20,'o20,'o20,'o20,'o20,'o20,'o20,
    'o20,'o20,'o20,'o20,'o20,'o20,'o20,'o20,'o20,'o20,'o20,'o20,'o20,'o20,'o20,'o20,
    'o20,'o52,'o37,'o20,'o53,'o20,'o20,'o14,'o34,'o74,'o54,'o60,'o33,'o40,'o73,'o21,
    'o12,'o01,'o02,'o03,'o04,'o05,'o06,'o07,'o10,'o11,'o20,'o56,'o76,'o13,'o16,'o72,
    'o20,'o61,'o62,'o63,'o64,'o65,'o66,'o67,'o70,'o71,'o41,'o42,'o43,'o44,'o45,'o46,
    'o47,'o50,'o51,'o22,'o23,'o24,'o25,'o26,'o27,'o30,'o31,'o75,'o36,'o55,'o20,'o57,
    'o20,'o61,'o62,'o63,'o64,'o65,'o66,'o67,'o70,'o71,'o41,'o42,'o43,'o44,'o45,'o46,
    'o47,'o50,'o51,'o22,'o23,'o24,'o25,'o26,'o27,'o30,'o31,'o17,'o32,'o77,'o35,'o20
  };

  logic      alt_sel;
  int        rec_len;
  int        blk_len;
  int        rec_pos;
  int        blk_pos;
  bit        skipping;
  tape_run_t runs_due_q [$];
  tape_run_t step_runs [4];
  int        step_n;

  task report(input string msg);
    fail_count++;
    $display("%0t tape checker: %s", $time, msg);
  endtask

  // BCD code with even parity in bit 6
  function automatic logic [6:0] encode_char(input logic [6:0] ch);
    logic [5:0] b;
    b = alt_sel ? alt_bcd[ch] : std_bcd[ch];
    return {^b, b};
  endfunction

  task add_run(input logic [7:0] tb, input int len);
    if (len == 0 || step_n >= 4) return;
    step_runs[step_n] = '{tape_byte: tb, run_length: 15'(len), last_of_run: 1'b0};
    step_n++;
  endtask

  task add_record_pos(input int n);
    rec_pos = (rec_pos + n > int'(RECORD_CAP)) ? int'(RECORD_CAP) : rec_pos + n;
  endtask

  task add_block_pos(input int n);
    blk_pos = (blk_pos + n > int'(BLOCK_CAP)) ? int'(BLOCK_CAP) : blk_pos + n;
  endtask

  task emit_blanks(input int count);
    logic [7:0] b;
    b = {1'b0, encode_char(CH_SPACE)};
    if (count == 0) return;
    if (blk_pos == 0) begin
      add_run(b | START_BIT, 1);
      add_block_pos(1);
      count--;
    end
    add_run(b, count);
    add_block_pos(count);
  endtask

  task pad_record();
    if (rec_pos < rec_len) emit_blanks(rec_len - rec_pos);
    rec_pos = 0;
  endtask

  task predict_tape(input logic act, input logic [6:0] ch);
    logic [7:0] b;
    int         fill;
    step_n = 0;
    if (act == ACT_END) begin
      if (rec_pos > 0) pad_record();
      blk_pos  = 0;
      skipping = 1'b0;
      add_run(MARK_BYTE, 2);
    end else if (skipping) begin
      if (ch == CH_LF) skipping = 1'b0;
    end else if (ch == CH_CR) begin
      // dropped
    end else if (ch == CH_LF) begin
      pad_record();
      // close the block when another record would not fit; overlong blocks get no pad
      if (blk_pos + rec_len > blk_len) begin
        if (blk_pos < blk_len) emit_blanks(blk_len - blk_pos);
        blk_pos = 0;
      end
    end else if (ch == CH_FF || ch == CH_TILDE) begin
      blk_pos = 0;
      add_run(MARK_BYTE, 1);
      skipping = 1'b1;
    end else if (ch == CH_TAB) begin
      b    = {1'b0, encode_char(CH_SPACE)};
      fill = (8 - ((rec_pos + 1) & 7)) & 7;
      add_run((blk_pos == 0) ? (b | START_BIT) : b, 1);
      add_block_pos(1);
      add_record_pos(1);
      add_run(b, fill);
      add_block_pos(fill);
      add_record_pos(fill);
    end else begin
      b = {1'b0, encode_char(ch)};
      add_run((blk_pos == 0) ? (b | START_BIT) : b, 1);
      add_block_pos(1);
      add_record_pos(1);
    end
    if (step_n > 0) step_runs[step_n - 1].last_of_run = 1'b1;
    for (int i = 0; i < step_n; i++) runs_due_q.push_back(step_runs[i]);
  endtask

  task check_run();
    tape_run_t want;
    if (runs_due_q.size() == 0) begin
      report($sformatf("unexpected run byte %o len %0d last %b",
                       out_tape_byte, out_run_length, out_last_of_run));
      return;
    end
    want = runs_due_q.pop_front();
    if (out_tape_byte !== want.tape_byte)
      report($sformatf("tape_byte %o, want %o", out_tape_byte, want.tape_byte));
    if (out_run_length !== want.run_length)
      report($sformatf("run_length %0d, want %0d", out_run_length, want.run_length));
    if (out_last_of_run !== want.last_of_run)
      report($sformatf("last_of_run %b, want %b", out_last_of_run, want.last_of_run));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      alt_sel  = 1'b0;
      rec_len  = int'(RECORD_LENGTH_RST);
      blk_len  = int'(BLOCK_LENGTH_RST);
      rec_pos  = 0;
      blk_pos  = 0;
      skipping = 1'b0;
      runs_due_q.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_ALT_CHARSET:   alt_sel = cfg_wdata[0];
          CFG_RECORD_LENGTH: rec_len = int'(cfg_wdata[11:0]);
          CFG_BLOCK_LENGTH:  blk_len = int'(cfg_wdata[14:0]);
          default: ;
        endcase
      end
      if (in_valid && !in_stall) predict_tape(in_action, in_text_char);
      if (out_valid && !out_stall) check_run();
    end
    runs_due = runs_due_q.size();
  end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import tbte_pkg::*;
  import tape_text_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [1:0]  cfg_index;
  logic [14:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic        in_action;
  logic [6:0]  in_text_char;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_tape_byte;
  logic [14:0] out_run_length;
  logic        out_last_of_run;
  int          fail_count;
  int          runs_due;

  bit idle_on;
  int stall_left;

  text_to_bcd_tape_encoder_unit i_dut (.*);

  tape_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // result side back-pressure in random bursts
  initial begin
    out_stall  = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (idle_on && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 19);
      end
    end
  end

  // called and returns at a falling edge; valid stays high for the next item
  task automatic send_item(input logic act, input logic [6:0] ch);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_action    <= act;
    in_text_char <= ch;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // idle wait also covers newlines still in flight that produce no runs
  task automatic drain();
    in_valid <= 1'b0;
    while (runs_due != 0) @(negedge clk);
    repeat (64) @(negedge clk);
  endtask

  task automatic set_config(input logic alt, input int rl, input int bl);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_ALT_CHARSET;
    cfg_wdata <= {14'd0, alt};
    @(negedge clk);
    cfg_index <= CFG_RECORD_LENGTH;
    cfg_wdata <= 15'(rl);
    @(negedge clk);
    cfg_index <= CFG_BLOCK_LENGTH;
    cfg_wdata <= 15'(bl);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic random_text(input int target);
    int         done;
    int         len;
    int         r;
    logic [6:0] ch;
    done = 0;
    while (done < target) begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        // text line, sometimes longer than record and block
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 12);
        for (int k = 0; k < len; k++) begin
          r = $urandom_range(0, 99);
          if (r < 10) ch = CH_TAB;
          else if (r < 14) ch = 7'($urandom_range(0, 127));
          else ch = 7'($urandom_range(32, 125));
          send_item(ACT_TEXT, ch);
        end
        if ($urandom_range(0, 6) == 0) begin
          send_item(ACT_TEXT, CH_CR);
          done++;
        end
        send_item(ACT_TEXT, CH_LF);
        done += len + 1;
      end else if (r < 77) begin
        // mark, discarded text, newline
        send_item(ACT_TEXT, ($urandom_range(0, 1) == 1) ? CH_FF : CH_TILDE);
        len = $urandom_range(0, 4);
        for (int k = 0; k < len; k++) send_item(ACT_TEXT, 7'($urandom_range(0, 127)));
        send_item(ACT_TEXT, CH_LF);
        done += len + 2;
      end else if (r < 87) begin
        send_item(ACT_END, 7'($urandom_range(0, 127)));
        done++;
      end else begin
        len = $urandom_range(1, 3);
        for (int k = 0; k < len; k++) send_item(ACT_TEXT, 7'($urandom_range(0, 127)));
        done += len;
      end
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_index    = CFG_ALT_CHARSET;
    cfg_wdata    = '0;
    in_valid     = 1'b0;
    in_action    = ACT_TEXT;
    in_text_char = '0;
    idle_on      = 1'b1;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed, reset lengths: 80 per record, 84 per block
    send_item(ACT_TEXT, 7'h41);
    send_item(ACT_TEXT, 7'h7A);
    send_item(ACT_TEXT, 7'h00);
    send_item(ACT_TEXT, 7'h7F);
    send_item(ACT_TEXT, CH_TAB);
    send_item(ACT_TEXT, CH_CR);
    send_item(ACT_TEXT, CH_LF);
    send_item(ACT_TEXT, CH_FF);
    send_item(ACT_TEXT, 7'h78);
    send_item(ACT_TEXT, CH_LF);
    send_item(ACT_TEXT, 7'h42);
    send_item(ACT_TEXT, CH_TILDE);
    send_item(ACT_TEXT, 7'h71);
    send_item(ACT_TEXT, CH_LF);
    send_item(ACT_TEXT, CH_TAB);
    send_item(ACT_TEXT, CH_TAB);
    send_item(ACT_TEXT, CH_LF);
    send_item(ACT_END, 7'h00);
    send_item(ACT_TEXT, 7'h43);
    send_item(ACT_END, 7'h7F);
    // end of text while discarding after a mark
    send_item(ACT_TEXT, CH_FF);
    send_item(ACT_END, 7'h55);
    send_item(ACT_TEXT, CH_LF);
    send_item(ACT_END, 7'h2A);
    drain();

    for (int p = 0; p < 9; p++) begin
      case (p)
        0: set_config(1'b1, 1, 1);
        1: set_config(1'b0, 4095, 32767);
        2: set_config(1'b1, 8, 20);
        3: set_config(1'b0, 0, 0);
        default: set_config(1'($urandom_range(0, 1)), $urandom_range(1, 100),
                            $urandom_range(1, 200));
      endcase
      if (p == 8) idle_on = 1'b0;
      random_text(43);
      drain();
    end

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
